[hdl/toroidal_grid_wavefront_step_top_defines.svh]
// Assertion macros shared by the wavefront step block.
`ifndef TOROIDAL_GRID_WAVEFRONT_STEP_TOP_DEFINES_SVH
`define TOROIDAL_GRID_WAVEFRONT_STEP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check, masked while reset is active.
`define TWF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("twf assertion failed");

// Clocked check that also holds during reset.
`define TWF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("twf assertion failed");

`else

`define TWF_ASSERT(name, clk, rst_n, prop)
`define TWF_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

[hdl/twf_pkg.sv]
// Package of types and constants for the toroidal wavefront step block.
`default_nettype none

package twf_pkg;

  localparam int MAX_SIDE_LOG2 = 8;

  localparam logic [7:0] MARK_BIT  = 8'h20;
  localparam logic [7:0] MARK_CLR  = 8'hdf;

  localparam logic [3:0] RESET_LOG2 = 4'd8;
  localparam logic [3:0] MIN_HEIGHT_LOG2 = 4'd2;

  // register indexes on the configuration port
  localparam logic [3:0] CFG_WIDTH_LOG2  = 4'd0;
  localparam logic [3:0] CFG_HEIGHT_LOG2 = 4'd1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [7:0] cell_value;
    logic [7:0] seed_level;
    logic [7:0] paint_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    logic [3:0] reg_index;
    logic [3:0] wdata;
  } cfg_item_t;

  typedef enum logic [2:0] {
    ADDR_INPUT = 3'd0,
    ADDR_HERE  = 3'd1,
    ADDR_YP    = 3'd2,
    ADDR_YM    = 3'd3,
    ADDR_XP    = 3'd4,
    ADDR_XM    = 3'd5
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_INPUT = 2'd0,
    WD_MARK  = 2'd1,
    WD_CLEAR = 2'd2
  } wd_sel_e;

  typedef struct packed {
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      re;
    logic      we;
    logic      we_if_hit;
    logic      load_args;
    logic      load_here;
    logic      hit_first;
    logic      hit_acc;
    logic      cnt_clear;
    logic      cnt_step;
    logic      out_load;
    logic      out_from_mem;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last_cell;
  } status_t;

endpackage

`default_nettype wire

[hdl/twf_if.sv]
// Handshake interfaces for the item, result and configuration channels.
`default_nettype none

interface twf_in_if ();
  logic               valid;
  logic               ready;
  twf_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface twf_out_if ();
  logic               valid;
  logic               ready;
  twf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface twf_cfg_if ();
  logic               valid;
  logic               ready;
  twf_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/twf_ctrl.sv]
// Sequencer for cell access and the two-pass wavefront step.
`default_nettype none

module twf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire twf_pkg::op_e     op_i,
  input  wire twf_pkg::status_t status_i,
  output logic                  in_ready_o,
  output twf_pkg::cmd_t         cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_RDOUT   = 11'b000_0000_0010,
    ST_P1_HERE = 11'b000_0000_0100,
    ST_P1_YP   = 11'b000_0000_1000,
    ST_P1_YM   = 11'b000_0001_0000,
    ST_P1_XP   = 11'b000_0010_0000,
    ST_P1_XM   = 11'b000_0100_0000,
    ST_P1_WR   = 11'b000_1000_0000,
    ST_P2_RD   = 11'b001_0000_0000,
    ST_P2_WR   = 11'b010_0000_0000,
    ST_FIN     = 11'b100_0000_0000
  } state_e;

  state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.addr_sel = twf_pkg::ADDR_HERE;
    cmd_o.wd_sel   = twf_pkg::WD_INPUT;
    case (st_q)
      ST_IDLE: begin
        in_ready_o = status_i.slot_free;
        if (in_valid_i && status_i.slot_free) begin
          case (op_i)
            twf_pkg::OP_WRITE: begin
              cmd_o.addr_sel = twf_pkg::ADDR_INPUT;
              cmd_o.we       = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            twf_pkg::OP_READ: begin
              cmd_o.addr_sel = twf_pkg::ADDR_INPUT;
              cmd_o.re       = 1'b1;
              st_d           = ST_RDOUT;
            end
            twf_pkg::OP_STEP: begin
              cmd_o.load_args = 1'b1;
              cmd_o.cnt_clear = 1'b1;
              st_d            = ST_P1_HERE;
            end
            default: begin
              cmd_o.out_load = 1'b1;
            end
          endcase
        end
      end
      ST_RDOUT: begin
        if (status_i.slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          st_d               = ST_IDLE;
        end
      end
      ST_P1_HERE: begin
        cmd_o.re = 1'b1;
        st_d     = ST_P1_YP;
      end
      ST_P1_YP: begin
        cmd_o.load_here = 1'b1;
        cmd_o.addr_sel  = twf_pkg::ADDR_YP;
        cmd_o.re        = 1'b1;
        st_d            = ST_P1_YM;
      end
      ST_P1_YM: begin
        cmd_o.hit_first = 1'b1;
        cmd_o.addr_sel  = twf_pkg::ADDR_YM;
        cmd_o.re        = 1'b1;
        st_d            = ST_P1_XP;
      end
      ST_P1_XP: begin
        cmd_o.hit_acc  = 1'b1;
        cmd_o.addr_sel = twf_pkg::ADDR_XP;
        cmd_o.re       = 1'b1;
        st_d           = ST_P1_XM;
      end
      ST_P1_XM: begin
        cmd_o.hit_acc  = 1'b1;
        cmd_o.addr_sel = twf_pkg::ADDR_XM;
        cmd_o.re       = 1'b1;
        st_d           = ST_P1_WR;
      end
      ST_P1_WR: begin
        cmd_o.we_if_hit = 1'b1;
        cmd_o.wd_sel    = twf_pkg::WD_MARK;
        cmd_o.cnt_step  = 1'b1;
        st_d            = status_i.last_cell ? ST_P2_RD : ST_P1_HERE;
      end
      ST_P2_RD: begin
        cmd_o.re = 1'b1;
        st_d     = ST_P2_WR;
      end
      ST_P2_WR: begin
        cmd_o.we       = 1'b1;
        cmd_o.wd_sel   = twf_pkg::WD_CLEAR;
        cmd_o.cnt_step = 1'b1;
        st_d           = status_i.last_cell ? ST_FIN : ST_P2_RD;
      end
      ST_FIN: begin
        if (status_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          st_d           = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/twf_datapath.sv]
// Cell store, scan counters, neighbour compare and result register.
`default_nettype none

module twf_datapath #(
  parameter int MAX_SIDE_LOG2 = twf_pkg::MAX_SIDE_LOG2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire twf_pkg::cmd_t      cmd_i,
  input  wire twf_pkg::in_item_t  item_i,
  input  wire logic               cfg_we_i,
  input  wire twf_pkg::cfg_item_t cfg_i,
  input  wire logic               out_ready_i,
  output twf_pkg::status_t        status_o,
  output logic                    out_valid_o,
  output twf_pkg::out_item_t      out_item_o
);

  localparam int S     = MAX_SIDE_LOG2;
  localparam int LW    = $clog2(MAX_SIDE_LOG2 + 1);
  localparam int AW    = 2 * MAX_SIDE_LOG2;
  localparam int DEPTH = 1 << AW;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  logic [3:0] width_log2_q, height_log2_q;
  logic [LW-1:0] eff_w, eff_h;
  logic [S-1:0]  wmask, hmask;

  logic [S-1:0] x_q, y_q;
  logic [S-1:0] xp, xm, yp, ym;
  logic [7:0]   src_q, fill_q, here_q;
  logic         hit_q, src_eq, mark_now;

  logic [AW-1:0] addr;
  logic [7:0]    wdata;
  logic          we;

  logic          out_valid_q;
  logic [7:0]    out_value_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= twf_pkg::RESET_LOG2;
      height_log2_q <= twf_pkg::RESET_LOG2;
    end else if (cfg_we_i) begin
      if (cfg_i.reg_index == twf_pkg::CFG_WIDTH_LOG2) begin
        width_log2_q <= cfg_i.wdata;
      end
      if (cfg_i.reg_index == twf_pkg::CFG_HEIGHT_LOG2) begin
        height_log2_q <= cfg_i.wdata;
      end
    end
  end

  // clamp extents into the legal range
  always_comb begin
    if (width_log2_q > 4'(MAX_SIDE_LOG2)) begin
      eff_w = LW'(MAX_SIDE_LOG2);
    end else begin
      eff_w = width_log2_q[LW-1:0];
    end
    if (height_log2_q < twf_pkg::MIN_HEIGHT_LOG2) begin
      eff_h = LW'(twf_pkg::MIN_HEIGHT_LOG2);
    end else if (height_log2_q > 4'(MAX_SIDE_LOG2)) begin
      eff_h = LW'(MAX_SIDE_LOG2);
    end else begin
      eff_h = height_log2_q[LW-1:0];
    end
  end

  assign wmask = ~({S{1'b1}} << eff_w);
  assign hmask = ~({S{1'b1}} << eff_h);

  assign yp = (y_q + S'(1)) & hmask;
  assign ym = (y_q - S'(1)) & hmask;
  assign xp = (x_q + S'(1)) & wmask;
  assign xm = (x_q - S'(1)) & wmask;

  assign status_o.last_cell = (x_q == wmask) && (y_q == hmask);

  // scan counters, Y inner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (cmd_i.cnt_clear) begin
      x_q <= '0;
      y_q <= '0;
    end else if (cmd_i.cnt_step) begin
      if (y_q == hmask) begin
        y_q <= '0;
        x_q <= xp;
      end else begin
        y_q <= yp;
      end
    end
  end

  assign src_eq   = (rdata_q == src_q);
  assign mark_now = (here_q < src_q) && (hit_q || src_eq);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_args) begin
      src_q  <= item_i.seed_level;
      fill_q <= item_i.paint_value;
    end
    if (cmd_i.load_here) begin
      here_q <= rdata_q;
    end
    if (cmd_i.hit_first) begin
      hit_q <= src_eq;
    end else if (cmd_i.hit_acc) begin
      hit_q <= hit_q | src_eq;
    end
  end

  always_comb begin
    case (cmd_i.addr_sel)
      twf_pkg::ADDR_INPUT: addr = {item_i.cell_x[S-1:0], item_i.cell_y[S-1:0]};
      twf_pkg::ADDR_YP:    addr = {x_q, yp};
      twf_pkg::ADDR_YM:    addr = {x_q, ym};
      twf_pkg::ADDR_XP:    addr = {xp, y_q};
      twf_pkg::ADDR_XM:    addr = {xm, y_q};
      default:             addr = {x_q, y_q};
    endcase
    case (cmd_i.wd_sel)
      twf_pkg::WD_MARK:  wdata = fill_q | twf_pkg::MARK_BIT;
      twf_pkg::WD_CLEAR: wdata = rdata_q & twf_pkg::MARK_CLR;
      default:           wdata = item_i.cell_value;
    endcase
  end

  assign we = cmd_i.we || (cmd_i.we_if_hit && mark_now);

  // single-port store, read data registered and held between reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.re) begin
      rdata_q <= mem[addr];
    end
  end

  // result register
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= cmd_i.out_from_mem ? rdata_q : 8'h00;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_item_o.read_value = out_value_q;
  assign out_item_o.done_res   = 1'b1;

endmodule

`default_nettype wire

[hdl/toroidal_grid_wavefront_step_top.sv]
// Top level of the toroidal grid wavefront step block.
//
//  channel  dir  payload                                            beat when
//  in_i     in   operation, cell_x/y, cell_value, source, fill      valid & ready
//  out_o    out  read_value, done_res                               valid & ready
//  cfg_i    in   reg_index, wdata (0 width_log2, 1 height_log2)     valid & ready
//
// Cell write / unused code: accepted, and the answer is loaded straight into the result slot.
// Cell read: the store read is registered, then moved to the result once the slot is free.
// Step: over the single store port, pass one reads each cell and its four neighbours, then
// writes the mark if one is due; pass two reads each cell and writes it back with the mark cleared.
// Reset sets width_log2 and height_log2 to 8; the store itself is not cleared.
// A new item is taken only while the result slot is empty or draining.
`default_nettype none

`include "toroidal_grid_wavefront_step_top_defines.svh"

module toroidal_grid_wavefront_step_top #(
  parameter int MAX_SIDE_LOG2 = twf_pkg::MAX_SIDE_LOG2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  twf_in_if.sink    in_i,
  twf_out_if.source out_o,
  twf_cfg_if.sink   cfg_i
);

  twf_pkg::cmd_t    cmd;
  twf_pkg::status_t status;
  logic             in_ready;

  // beat decode used by the checks below
  logic       in_beat;
  logic [1:0] in_op;
  logic       quick_beat;
  logic       read_beat;

  // configuration is always taken; the user must only write it while the block is idle, the block does not enforce this
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  twf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (twf_pkg::op_e'(in_i.data.operation)),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  twf_datapath #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (in_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_i       (cfg_i.data),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.data)
  );

  assign in_beat    = in_i.valid && in_i.ready;
  assign in_op      = in_i.data.operation;
  assign quick_beat = in_beat && (in_op == twf_pkg::OP_WRITE || in_op == twf_pkg::OP_NONE);
  assign read_beat  = in_beat && (in_op == twf_pkg::OP_READ);

  // a beat is only taken when the result slot can hold its answer
  `TWF_ASSERT(a_ready_needs_slot, clk_i, rst_ni, in_i.ready |-> (!out_o.valid || out_o.ready))

  // write and unused codes answer at the next edge
  `TWF_ASSERT(a_write_answers, clk_i, rst_ni, quick_beat |=> out_o.valid)

  // a read leaves the slot empty after its beat, then answers from the registered store read
  `TWF_ASSERT(a_read_answers, clk_i, rst_ni, read_beat |=> (!out_o.valid ##1 out_o.valid))

  // no result is pending straight out of reset
  `TWF_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_o.valid)

endmodule

`default_nettype wire
